// ----- rtl/sbmq_pkg.sv -----
// Package with the word types and status codes of the shared-buffer multi-queue.
`default_nettype none

package sbmq_pkg;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               action;
    logic        [1:0]  queue_id;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] pop_value;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/sbmq_ram.sv -----
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none

module sbmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wa,
  input  wire logic [WIDTH-1:0] wd,
  input  wire logic [AW-1:0]    ra,
  output logic      [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

// ----- rtl/shared_buffer_multi_queue.sv -----
// Top level of the shared-buffer multi-queue: control sequencer around three RAMs.
//
// QUEUE_COUNT FIFO queues share SLOT_COUNT slots. Each word on the request side
// enqueues push_value into queue queue_id or dequeues from it, and gives exactly one
// response word with a status and the dequeued value. Slot values, slot links and
// the per-queue head/tail table live in synchronous RAMs with a registered read
// port; the free-list head and a fill count of never-used slots are registers.
// An enqueue reads the table and link, then writes back; a dequeue reads the table,
// then reads link and value at the head slot, then writes back; a dequeue that finds
// its queue empty ends after the table read, and a refused request goes straight
// to its response step. The block handles one word at a time and holds its final
// step while the response register is still occupied and stalled.
// After reset, a clearing pass sets all QUEUE_COUNT queue table entries to empty,
// and no request is taken until it is over.
`default_nettype none

module shared_buffer_multi_queue
  import sbmq_pkg::*;
#(
  parameter int SLOT_COUNT  = 8,
  parameter int QUEUE_COUNT = 4,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int LINK_W = $clog2(SLOT_COUNT + 1);
  localparam int SA_W   = $clog2(SLOT_COUNT);
  localparam int QID_W  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOT_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EB    = 3'd2;
  localparam logic [2:0] S_DB    = 3'd3;
  localparam logic [2:0] S_DC    = 3'd4;
  localparam logic [2:0] S_FAIL  = 3'd5;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [QID_W-1:0]       clr_cnt;
  logic                   op;
  logic [QID_W-1:0]       q_reg;
  logic [VALUE_WIDTH-1:0] val_reg;
  logic [LINK_W-1:0]      free_head;
  logic [LINK_W-1:0]      fresh;

  // Queue table entries hold {head, tail}.
  logic [2*LINK_W-1:0]    q_rd;
  logic [LINK_W-1:0]      head_rd;
  logic [LINK_W-1:0]      tail_rd;
  logic [LINK_W-1:0]      link_rd;
  logic [VALUE_WIDTH-1:0] val_rd;

  logic [QID_W+1:0]       req_q_ext;
  logic [QID_W-1:0]       req_q_idx;
  logic                   req_q_ok;
  logic [VALUE_WIDTH+31:0] push_ext;
  logic [VALUE_WIDTH+31:0] pop_ext;

  logic                   accept;
  logic                   out_free;
  logic                   commit;
  logic [LINK_W-1:0]      link_ra_full;
  logic [QID_W-1:0]       q_ra;
  logic                   q_we;
  logic [QID_W-1:0]       q_wa;
  logic [2*LINK_W-1:0]    q_wd;
  logic                   link_we;
  logic [LINK_W-1:0]      link_wa_full;
  logic [LINK_W-1:0]      link_wd;
  logic                   val_we;
  logic                   virgin;
  logic [LINK_W-1:0]      next_free;
  logic [LINK_W-1:0]      new_head;
  logic [1:0]             status_c;
  logic [31:0]            pop_c;

  assign head_rd = q_rd[2*LINK_W-1:LINK_W];
  assign tail_rd = q_rd[LINK_W-1:0];

  assign req_q_ext = {{QID_W{1'b0}}, req.queue_id};
  assign req_q_idx = req_q_ext[QID_W-1:0];
  assign req_q_ok  = 32'(req.queue_id) < QUEUE_COUNT;
  assign push_ext  = {{VALUE_WIDTH{1'b0}}, req.push_value};
  assign pop_ext   = {32'b0, val_rd};

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Slots at or above the fill count were never taken, so their link was never
  // written; only the free head can be such a slot.
  assign virgin    = (free_head == fresh);
  assign next_free = virgin ? (fresh + LINK_W'(1)) : link_rd;
  assign new_head  = (head_rd == tail_rd) ? NIL : link_rd;

  always_comb begin
    commit = 1'b0;
    unique case (state)
      S_EB, S_DC, S_FAIL: commit = out_free;
      S_DB:               commit = out_free && (head_rd == NIL);
      default:            commit = 1'b0;
    endcase
  end

  assign q_ra         = (state == S_IDLE) ? req_q_idx : q_reg;
  assign link_ra_full = ((state != S_IDLE) && (op == ACT_DEQ)) ? head_rd : free_head;

  always_comb begin
    q_we         = 1'b0;
    q_wa         = q_reg;
    q_wd         = {NIL, NIL};
    link_we      = 1'b0;
    link_wa_full = tail_rd;
    link_wd      = free_head;
    val_we       = 1'b0;
    status_c     = STATUS_DONE;
    pop_c        = 32'b0;
    unique case (state)
      S_CLEAR: begin
        q_we = 1'b1;
        q_wa = clr_cnt;
      end
      S_EB: begin
        q_we    = commit;
        q_wd    = (head_rd == NIL) ? {free_head, free_head} : {head_rd, free_head};
        link_we = commit && (head_rd != NIL);
        link_wd = free_head;
        val_we  = commit;
      end
      S_DB: begin
        status_c = STATUS_EMPTY;
      end
      S_DC: begin
        q_we         = commit;
        q_wd         = {new_head, tail_rd};
        link_we      = commit;
        link_wa_full = head_rd;
        link_wd      = free_head;
        pop_c        = pop_ext[31:0];
      end
      S_FAIL: begin
        status_c = (op == ACT_DEQ) ? STATUS_EMPTY : STATUS_FULL;
      end
      default: begin
      end
    endcase
  end

  sbmq_ram #(
    .WIDTH (2 * LINK_W),
    .DEPTH (QUEUE_COUNT),
    .AW    (QID_W)
  ) u_queue_ram (
    .clk (clk),
    .we  (q_we),
    .wa  (q_wa),
    .wd  (q_wd),
    .ra  (q_ra),
    .rd  (q_rd)
  );

  sbmq_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOT_COUNT),
    .AW    (SA_W)
  ) u_link_ram (
    .clk (clk),
    .we  (link_we),
    .wa  (link_wa_full[SA_W-1:0]),
    .wd  (link_wd),
    .ra  (link_ra_full[SA_W-1:0]),
    .rd  (link_rd)
  );

  sbmq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (SLOT_COUNT),
    .AW    (SA_W)
  ) u_value_ram (
    .clk (clk),
    .we  (val_we),
    .wa  (free_head[SA_W-1:0]),
    .wd  (val_reg),
    .ra  (head_rd[SA_W-1:0]),
    .rd  (val_rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == QID_W'(QUEUE_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req.action == ACT_ENQ) begin
            state_next = (req_q_ok && (free_head != NIL)) ? S_EB : S_FAIL;
          end else begin
            state_next = req_q_ok ? S_DB : S_FAIL;
          end
        end
      end
      S_DB: begin
        if (head_rd == NIL) begin
          if (commit) begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_DC;
        end
      end
      S_EB, S_DC, S_FAIL: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      free_head <= '0;
      fresh     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + QID_W'(1);
      end
      if (commit && (state == S_EB)) begin
        free_head <= next_free;
        if (virgin) begin
          fresh <= fresh + LINK_W'(1);
        end
      end else if (commit && (state == S_DC)) begin
        free_head <= head_rd;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= req.action;
      q_reg   <= req_q_idx;
      val_reg <= push_ext[VALUE_WIDTH-1:0];
    end
    if (commit) begin
      rsp.status    <= status_c;
      rsp.pop_value <= $signed(pop_c);
    end
  end

endmodule

`default_nettype wire
